/* hdl/edf_pkg.sv */
package edf_pkg;

  // Operation codes on in_operation
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes on out_status
  localparam logic [1:0] ST_LOADED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RAN    = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  localparam int          SUM_W   = 24;
  localparam logic [23:0] SUM_MAX = 24'hFF_FFFF;
  localparam logic [15:0] F16_MAX = 16'hFFFF;

  // One task slot, kept as a single memory word
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] deadline;
    logic [15:0] burst;
    logic [15:0] remaining;
  } task_entry_t;

endpackage

/* hdl/edf_preemptive_scheduler_unit.sv */
// Preemptive earliest-deadline-first scheduler.
// Input channel (in_valid/in_ready): one transaction is a command. A load stores
// a task (id, arrival, burst, deadline) in the next free slot; a tick picks the
// ready task (arrived, work left) with the smallest deadline, ties to the
// earlier arrival and then to the lower slot, runs it for one tick and advances
// time; a clear empties the table and zeroes time, counts and sums.
// Result channel (out_valid/out_ready): exactly one transaction per command,
// in command order, held in an output register until taken.
// Command flow: load, clear and unused codes go straight to the response state.
// A tick scans the table, writes back the picked task's remaining work when it
// runs one, and on completion adds the two saturating sums in S_SUB and S_SUM:
// the task table sits in one synchronous memory with a registered read port,
// and the scan reads one slot per cycle.
// One command is worked at a time; the next is accepted the cycle after the
// previous result has been loaded into the output register, so no new command
// is taken before the last one is through. A stalled receiver holds the block
// in its response state until the register frees up.
// Reset clears time, counts and sums; the table memory is not cleared, only
// slots below the task count are ever evaluated by the scan.
module edf_preemptive_scheduler_unit
  import edf_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_arrival,
  input  logic [15:0] in_burst,
  input  logic [15:0] in_deadline,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_task_id_res,
  output logic [15:0] out_tick_time,
  output logic        out_finished,
  output logic [15:0] out_turnaround,
  output logic [15:0] out_waiting,
  output logic [23:0] out_waiting_sum,
  output logic [23:0] out_turnaround_sum,
  output logic        out_all_done
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;   // time compare width
  localparam int ADD_W = ((CMP_W > SUM_W) ? CMP_W : SUM_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_SUB,
    S_SUM,
    S_RESP
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       task_cnt_r;
  logic [CNT_W-1:0]       done_cnt_r;
  logic [TIME_BITS-1:0]   cur_time_r;
  logic [SUM_W-1:0]       wait_tot_r;
  logic [SUM_W-1:0]       tat_tot_r;

  // scan control
  logic [CNT_W-1:0]       scan_idx_r;
  logic                   rd_pend_r;
  logic [IDX_W-1:0]       rd_slot_r;
  logic                   found_r;
  logic [IDX_W-1:0]       best_slot_r;
  task_entry_t            best_r;

  // completion arithmetic
  logic [CMP_W-1:0]       tat_r;
  logic [CMP_W-1:0]       wt_r;

  // pending result fields
  logic [1:0]             res_status_r;
  logic [7:0]             res_id_r;
  logic [15:0]            res_time_r;
  logic                   res_fin_r;

  // output register
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [7:0]             out_id_r;
  logic [15:0]            out_time_r;
  logic                   out_fin_r;
  logic [15:0]            out_tat_r;
  logic [15:0]            out_wt_r;
  logic [SUM_W-1:0]       out_wsum_r;
  logic [SUM_W-1:0]       out_tsum_r;
  logic                   out_done_r;

  // task memory
  task_entry_t            mem [MAX_TASKS];
  task_entry_t            mem_q_r;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  task_entry_t            mem_wd;
  logic [IDX_W-1:0]       mem_ra;

  logic                   accept;
  logic [CMP_W-1:0]       time_ext;
  logic [15:0]            time_sat16;
  logic                   cand_ready;
  logic                   cand_better;
  logic                   scan_issue;
  logic                   scan_done;
  logic [15:0]            load_burst;
  logic [ADD_W-1:0]       tat_sum;
  logic [ADD_W-1:0]       wt_sum;
  logic [CMP_W-1:0]       burst_ext;
  logic [CMP_W-1:0]       arr_ext;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign time_ext   = CMP_W'(cur_time_r);
  assign time_sat16 = (time_ext > CMP_W'(F16_MAX)) ? F16_MAX : time_ext[15:0];
  assign load_burst = (in_burst == 16'd0) ? 16'd1 : in_burst;

  // candidate evaluation on the word read in the previous cycle
  assign cand_ready  = (CMP_W'(mem_q_r.arrival) <= time_ext) && (mem_q_r.remaining != 16'd0);
  assign cand_better = !found_r || (mem_q_r.deadline < best_r.deadline) ||
                       ((mem_q_r.deadline == best_r.deadline) &&
                        (mem_q_r.arrival < best_r.arrival));

  assign scan_issue = (state_r == S_SCAN) && (scan_idx_r < task_cnt_r);
  assign scan_done  = (state_r == S_SCAN) && !scan_issue && !rd_pend_r;

  assign arr_ext   = CMP_W'(best_r.arrival);
  assign burst_ext = CMP_W'(best_r.burst);
  assign tat_sum   = ADD_W'(tat_tot_r) + ADD_W'(tat_r);
  assign wt_sum    = ADD_W'(wait_tot_r) + ADD_W'(wt_r);

  // memory port control; loads write at acceptance, ticks write back after
  // the scan ends, so a read never overlaps a write to the same slot
  always_comb begin
    mem_we = 1'b0;
    mem_wa = task_cnt_r[IDX_W-1:0];
    mem_wd = best_r;
    mem_ra = scan_idx_r[IDX_W-1:0];
    if (accept && (in_operation == OP_LOAD) && (task_cnt_r < CNT_W'(MAX_TASKS))) begin
      mem_we           = 1'b1;
      mem_wd.id        = in_task_id;
      mem_wd.arrival   = in_arrival;
      mem_wd.deadline  = in_deadline;
      mem_wd.burst     = load_burst;
      mem_wd.remaining = load_burst;
    end else if (state_r == S_WRITE) begin
      mem_we           = 1'b1;
      mem_wa           = best_slot_r;
      mem_wd.remaining = best_r.remaining - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      task_cnt_r  <= '0;
      done_cnt_r  <= '0;
      cur_time_r  <= '0;
      wait_tot_r  <= '0;
      tat_tot_r   <= '0;
      scan_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_id_r   <= 8'd0;
            res_time_r <= time_sat16;
            res_fin_r  <= 1'b0;
            tat_r      <= '0;
            wt_r       <= '0;
            state_r    <= S_RESP;
            case (in_operation)
              OP_LOAD: begin
                res_id_r <= in_task_id;
                if (task_cnt_r < CNT_W'(MAX_TASKS)) begin
                  task_cnt_r   <= task_cnt_r + CNT_W'(1);
                  res_status_r <= ST_LOADED;
                end else begin
                  res_status_r <= ST_FULL;
                end
              end
              OP_TICK: begin
                scan_idx_r <= '0;
                rd_pend_r  <= 1'b0;
                found_r    <= 1'b0;
                state_r    <= S_SCAN;
              end
              OP_CLEAR: begin
                task_cnt_r   <= '0;
                done_cnt_r   <= '0;
                cur_time_r   <= '0;
                wait_tot_r   <= '0;
                tat_tot_r    <= '0;
                res_time_r   <= 16'd0;
                res_status_r <= ST_LOADED;
              end
              default: begin
                res_status_r <= ST_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_pend_r <= scan_issue;
          if (scan_issue) begin
            rd_slot_r  <= scan_idx_r[IDX_W-1:0];
            scan_idx_r <= scan_idx_r + CNT_W'(1);
          end
          if (rd_pend_r && cand_ready && cand_better) begin
            found_r     <= 1'b1;
            best_r      <= mem_q_r;
            best_slot_r <= rd_slot_r;
          end
          if (scan_done) begin
            if (cur_time_r != {TIME_BITS{1'b1}}) begin
              cur_time_r <= cur_time_r + TIME_BITS'(1);
            end
            if (found_r) begin
              state_r <= S_WRITE;
            end else begin
              res_status_r <= ST_IDLE;
              state_r      <= S_RESP;
            end
          end
        end
        S_WRITE: begin
          // time already advanced; remaining work write-back happens here
          res_status_r <= ST_RAN;
          res_id_r     <= best_r.id;
          if (best_r.remaining == 16'd1) begin
            res_fin_r  <= 1'b1;
            done_cnt_r <= done_cnt_r + CNT_W'(1);
            tat_r      <= (time_ext > arr_ext) ? (time_ext - arr_ext) : '0;
            state_r    <= S_SUB;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_SUB: begin
          wt_r      <= (tat_r > burst_ext) ? (tat_r - burst_ext) : '0;
          tat_tot_r <= (tat_sum > ADD_W'(SUM_MAX)) ? SUM_MAX : tat_sum[SUM_W-1:0];
          state_r   <= S_SUM;
        end
        S_SUM: begin
          wait_tot_r <= (wt_sum > ADD_W'(SUM_MAX)) ? SUM_MAX : wt_sum[SUM_W-1:0];
          state_r    <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= res_id_r;
            out_time_r   <= res_time_r;
            out_fin_r    <= res_fin_r;
            out_tat_r    <= (tat_r > CMP_W'(F16_MAX)) ? F16_MAX : tat_r[15:0];
            out_wt_r     <= (wt_r > CMP_W'(F16_MAX)) ? F16_MAX : wt_r[15:0];
            out_wsum_r   <= wait_tot_r;
            out_tsum_r   <= tat_tot_r;
            out_done_r   <= (done_cnt_r == task_cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_task_id_res    = out_id_r;
  assign out_tick_time      = out_time_r;
  assign out_finished       = out_fin_r;
  assign out_turnaround     = out_tat_r;
  assign out_waiting        = out_wt_r;
  assign out_waiting_sum    = out_wsum_r;
  assign out_turnaround_sum = out_tsum_r;
  assign out_all_done       = out_done_r;

  // completions can never outnumber loaded tasks
  a_done_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    done_cnt_r <= task_cnt_r)
    else $error("completed count exceeds task count");

  // a finished report only comes with a task that ran
  a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |-> (out_status_r == ST_RAN))
    else $error("finished flag without a run status");

  // the table is never written while a scan reads it
  a_no_wr_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("memory write during scan");

  // the scan only picks a slot that is loaded
  a_pick_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (CNT_W'(best_slot_r) < task_cnt_r))
    else $error("picked slot beyond task count");

endmodule
